// ----- rtl/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants for the quantized ramp segment
// Level formats, register map, and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int LEVEL_BITS     = 32;
   localparam int HOLD_FRAC_BITS = 8;
   // Internal level width: two guard bits over the emitted level.
   localparam int INT_BITS       = LEVEL_BITS + 2;
   // Ramp-to-output distance: one more bit than an internal level.
   localparam int DIFF_BITS      = INT_BITS + 1;
   localparam int CFG_BITS       = 32;
   localparam int STEP_BITS      = 31;
   localparam int INC_BITS       = 31;
   localparam int HOLD_BITS      = 32;
   localparam int ADDR_BITS      = 5;
   localparam int REG_IDX_BITS   = 3;
   localparam int DIV_CNT_BITS   = $clog2(DIFF_BITS);

   localparam logic signed [INT_BITS-1:0] ONE_TICK = INT_BITS'(longint'(1) << HOLD_FRAC_BITS);
   localparam logic signed [INT_BITS-1:0] LIM_HI   =
      INT_BITS'((longint'(1) << (LEVEL_BITS - 1)) - 1);
   localparam logic signed [INT_BITS-1:0] LIM_LO   = -LIM_HI - INT_BITS'(1);

   localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(16777216);

   // Register map, byte address = 4 * index
   localparam logic [REG_IDX_BITS-1:0] REG_START_LEVEL    = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_END_LEVEL      = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_RAMP_INCREMENT = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_HOLD_RELOAD    = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_LEVEL_STEP     = 3'd4;

   typedef struct packed {
      logic signed [CFG_BITS-1:0] start_level;
      logic signed [CFG_BITS-1:0] end_level;
      logic [INC_BITS-1:0]        ramp_increment;
      logic [HOLD_BITS-1:0]       hold_reload;
      logic [STEP_BITS-1:0]       level_step;
   } cfg_type;

   typedef struct packed {
      logic start;     // start beat accepted
      logic tick;      // tick beat accepted
      logic check;     // test for quantize, load divider
      logic div_step;  // one remainder bit
      logic fix;       // snap output to the step grid
      logic emit;      // load result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } dp_status_type;

endpackage

// ----- rtl/qrs_req_if.sv -----
// ----------------------------------------------------------------------------
// qrs_req_if: request channel
// Valid/ready channel carrying one tick or start command per beat.
// ----------------------------------------------------------------------------
interface qrs_req_if;
   logic valid;
   logic ready;
   logic func;
   logic restart_level;

   modport source (output valid, output func, output restart_level, input ready);
   modport sink   (input valid, input func, input restart_level, output ready);
endinterface

// ----- rtl/qrs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// qrs_rsp_if: response channel
// Valid/ready channel carrying one quantized level per tick beat.
// ----------------------------------------------------------------------------
interface qrs_rsp_if;
   import qrs_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [LEVEL_BITS-1:0] level;
   logic                         done_res;

   modport source (output valid, output level, output done_res, input ready);
   modport sink   (input valid, input level, input done_res, output ready);
endinterface

// ----- rtl/qrs_csr.sv -----
// ----------------------------------------------------------------------------
// qrs_csr: configuration registers
// APB-style write/read access to the five segment registers.
// ----------------------------------------------------------------------------
module qrs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [qrs_pkg::ADDR_BITS-1:0] paddr,
   input  logic [qrs_pkg::CFG_BITS-1:0]  pwdata,
   output logic [qrs_pkg::CFG_BITS-1:0]  prdata,
   output logic                          pready,
   output qrs_pkg::cfg_type              cfg
);
   import qrs_pkg::*;

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic                    wr_en;
   logic [REG_IDX_BITS-1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[ADDR_BITS-1:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_START_LEVEL:    cfg_in.start_level    = $signed(pwdata);
            REG_END_LEVEL:      cfg_in.end_level      = $signed(pwdata);
            REG_RAMP_INCREMENT: cfg_in.ramp_increment = pwdata[INC_BITS-1:0];
            REG_HOLD_RELOAD:    cfg_in.hold_reload    = pwdata[HOLD_BITS-1:0];
            REG_LEVEL_STEP:     cfg_in.level_step     = pwdata[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_START_LEVEL:    prdata = cfg_ff.start_level;
         REG_END_LEVEL:      prdata = cfg_ff.end_level;
         REG_RAMP_INCREMENT: prdata = CFG_BITS'(cfg_ff.ramp_increment);
         REG_HOLD_RELOAD:    prdata = CFG_BITS'(cfg_ff.hold_reload);
         REG_LEVEL_STEP:     prdata = CFG_BITS'(cfg_ff.level_step);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_level    <= '0;
         cfg_ff.end_level      <= '0;
         cfg_ff.ramp_increment <= '0;
         cfg_ff.hold_reload    <= '0;
         cfg_ff.level_step     <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/qrs_dp.sv -----
// ----------------------------------------------------------------------------
// qrs_dp: ramp datapath
// Ramp, output level and hold counter, a bit-serial remainder unit for
// snapping to the step grid, and the saturating result register.
// ----------------------------------------------------------------------------
module qrs_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  qrs_pkg::cfg_type                    cfg,
   input  qrs_pkg::ctrl_cmd_type               cmd,
   input  logic                                restart_level,
   output qrs_pkg::dp_status_type              status,
   output logic signed [qrs_pkg::LEVEL_BITS-1:0] level,
   output logic                                done_res
);
   import qrs_pkg::*;

   logic signed [INT_BITS-1:0]   ramp_ff, ramp_in;
   logic signed [INT_BITS-1:0]   out_ff, out_in;
   logic signed [INT_BITS-1:0]   hold_ff, hold_in;
   logic                         up_ff, up_in;
   logic                         fin_ff, fin_in;
   logic                         pend_ff, pend_in;
   logic [DIFF_BITS-1:0]         quo_ff, quo_in;
   logic [STEP_BITS-1:0]         rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic signed [LEVEL_BITS-1:0] level_ff, level_in;
   logic                         done_ff, done_in;

   logic signed [INT_BITS-1:0]   y0, y1, inc, reload, pad_ext, sat;
   logic signed [DIFF_BITS-1:0]  diff;
   logic [STEP_BITS-1:0]         step, pad;
   logic [STEP_BITS:0]           trial;
   logic                         moving, hold_pos;

   assign y0       = INT_BITS'($signed(cfg.start_level));
   assign y1       = INT_BITS'($signed(cfg.end_level));
   assign inc      = $signed(INT_BITS'(cfg.ramp_increment));
   assign reload   = $signed(INT_BITS'(cfg.hold_reload));
   // zero step behaves as one LSB
   assign step     = (cfg.level_step == '0) ? STEP_BITS'(1) : cfg.level_step;
   assign moving   = up_ff ? (ramp_ff < y1) : (ramp_ff > y1);
   assign hold_pos = !hold_ff[INT_BITS-1] && (hold_ff != '0);
   // distance can exceed the internal level range, so one extra bit
   assign diff     = up_ff ? (DIFF_BITS'(ramp_ff) - DIFF_BITS'(out_ff))
                           : (DIFF_BITS'(out_ff) - DIFF_BITS'(ramp_ff));
   assign trial    = {rem_ff, quo_ff[DIFF_BITS-1]};
   assign pad      = (rem_ff == '0) ? '0 : (step - rem_ff);
   assign pad_ext  = $signed(INT_BITS'(pad));

   always_comb begin
      if (out_ff > LIM_HI) begin
         sat = LIM_HI;
      end else if (out_ff < LIM_LO) begin
         sat = LIM_LO;
      end else begin
         sat = out_ff;
      end
   end

   assign status.need_div = pend_ff && !diff[DIFF_BITS-1] && (diff != '0);
   assign status.div_last = (cnt_ff == DIV_CNT_BITS'(DIFF_BITS - 1));
   assign level           = level_ff;
   assign done_res        = done_ff;

   always_comb begin
      ramp_in  = ramp_ff;
      out_in   = out_ff;
      hold_in  = hold_ff;
      up_in    = up_ff;
      fin_in   = fin_ff;
      pend_in  = pend_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      level_in = level_ff;
      done_in  = done_ff;

      if (cmd.start) begin
         up_in   = (y1 >= y0);
         out_in  = restart_level ? y0 : out_ff;
         ramp_in = restart_level ? y0 : out_ff;
         hold_in = reload;
         fin_in  = 1'b0;
         pend_in = 1'b0;
      end

      if (cmd.tick) begin
         pend_in = 1'b0;
         if (!fin_ff) begin
            if (moving) begin
               ramp_in = up_ff ? (ramp_ff + inc) : (ramp_ff - inc);
               if (hold_pos) begin
                  hold_in = hold_ff - ONE_TICK;
               end else begin
                  hold_in = reload;
                  pend_in = 1'b1;
               end
            end else begin
               out_in = y1;
               fin_in = 1'b1;
            end
         end
      end

      // remainder of distance by step, MSB first
      if (cmd.check) begin
         quo_in = diff;
         rem_in = '0;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         quo_in = quo_ff << 1;
         if (trial >= {1'b0, step}) begin
            rem_in = STEP_BITS'(trial - {1'b0, step});
         end else begin
            rem_in = trial[STEP_BITS-1:0];
         end
         cnt_in = cnt_ff + DIV_CNT_BITS'(1);
      end

      // round the distance up to whole steps: land on ramp plus pad
      if (cmd.fix) begin
         out_in  = up_ff ? (ramp_ff + pad_ext) : (ramp_ff - pad_ext);
         pend_in = 1'b0;
      end

      if (cmd.emit) begin
         level_in = LEVEL_BITS'(sat);
         done_in  = fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff <= '0;
         out_ff  <= '0;
         hold_ff <= '0;
         up_ff   <= 1'b1;
         fin_ff  <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         ramp_ff <= ramp_in;
         out_ff  <= out_in;
         hold_ff <= hold_in;
         up_ff   <= up_in;
         fin_ff  <= fin_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      level_ff <= level_in;
      done_ff  <= done_in;
   end

endmodule

// ----- rtl/qrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// qrs_ctrl: segment controller
// Sequences tick evaluation, the remainder loop and result hand-off.
// ----------------------------------------------------------------------------
module qrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_func,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   input  qrs_pkg::dp_status_type status,
   output qrs_pkg::ctrl_cmd_type  cmd
);
   import qrs_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_FIX   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.start    = accept && req_func;
      cmd.tick     = accept && !req_func;
      case (state_ff)
         S_IDLE: begin
            if (accept && !req_func) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.need_div ? S_DIV : S_EMIT;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/quantized_ramp_segment.sv -----
// ----------------------------------------------------------------------------
// quantized_ramp_segment: linear envelope segment with quantized output
// Top level joining config registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage
//   req_bus carries one command per beat: func=1 starts a segment (direction
//   from start_level/end_level, optional jump to start_level when
//   restart_level=1, hold counter reload, done cleared); func=0 is one tick.
//   A start beat produces nothing on rsp_bus. Each tick beat produces exactly
//   one rsp_bus beat with the saturated Q8.24 level and the done flag.
//   Sequencing: beats are taken only in idle, where a start completes. A tick
//   runs check and emit, plus the bit-serial remainder loop and fix when the
//   hold counter expires and the output lags the ramp, so it is snapped to
//   the step grid; the loop does one bit per cycle over the 35-bit distance.
//   The result sits in an output register, so req_ready returns once the
//   result is loaded even if rsp_bus has not taken it. A receiver stall only
//   holds the next tick in the emit state until the register frees up.
//   Registers live on the APB-style port at 4*index; pready is tied high and
//   writes are meant for idle periods only.
//   Reset (synchronous, active high) clears the ramp, level and hold state,
//   sets direction up, clears done and restores level_step to 1.0.
// ----------------------------------------------------------------------------
module quantized_ramp_segment (
   input  logic                          clock,
   input  logic                          reset,
   qrs_req_if.sink                       req_bus,
   qrs_rsp_if.source                     rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [qrs_pkg::ADDR_BITS-1:0] paddr,
   input  logic [qrs_pkg::CFG_BITS-1:0]  pwdata,
   output logic [qrs_pkg::CFG_BITS-1:0]  prdata,
   output logic                          pready
);
   import qrs_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // register file: live values, read wherever the datapath needs them
   qrs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: accept, evaluate, remainder loop, snap, emit
   qrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // restart_level is only sampled with cmd.start, in the accept cycle
   qrs_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .restart_level (req_bus.restart_level),
      .status        (status),
      .level         (rsp_bus.level),
      .done_res      (rsp_bus.done_res)
   );

endmodule

// ----- rtl/qrs_checker.sv -----
// ----------------------------------------------------------------------------
// qrs_checker: port-level checks for the ramp segment
// Bound to the top level; watches the request and response channels.
// ----------------------------------------------------------------------------
module qrs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_func,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [qrs_pkg::LEVEL_BITS-1:0] rsp_level,
   input logic                          rsp_done
);
   import qrs_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level) && $stable(rsp_done))
      else $error("response beat dropped or changed under stall");

   // nothing pending after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a start beat never produces a result
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func |=> !$rose(rsp_valid))
      else $error("result appeared after a start beat");

   // a tick beat occupies the block for at least its evaluation cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_func |=> !req_ready)
      else $error("tick beat followed by immediate accept");

endmodule

bind quantized_ramp_segment qrs_checker u_qrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_func  (req_bus.func),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_level (rsp_bus.level),
   .rsp_done  (rsp_bus.done_res)
);

// ----- test/tb_quantized_ramp_segment.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quantized_ramp_segment: self-checking bench for the quantized ramp segment
// Drives start and tick beats and programs the five registers over APB
// between segments. A scoreboard class tracks the ramp, hold counter and
// stepped output level bit for bit and checks every response beat in order.
// Both channels idle at random, and the receiver holds off long enough to
// back the block up.
// ----------------------------------------------------------------------------
module tb_quantized_ramp_segment;
   import qrs_pkg::*;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   localparam int ITEM_TARGET     = 1900;
   localparam int STEADY_FROM     = ITEM_TARGET * 17 / 20;  // no idling past this
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_PAD       = 50;    // margin past the longest tick
   localparam int HOLD_OFF_CYCLES = 300;

   // One expected response beat.
   typedef struct {
      logic signed [LEVEL_BITS-1:0] level;
      logic                         done_res;
   } level_beat_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of registers and segment state, queue of the
   // levels each accepted tick should produce.
   // -------------------------------------------------------------------------
   class ramp_level_tracker;
      longint         cfg_start, cfg_end, cfg_inc, cfg_hold, cfg_step;
      longint         ramp_value, out_level, hold_count;
      bit             going_up, finished;
      level_beat_type levels_due[$];
      int             mismatches, ticks, starts, done_ticks, clipped, snaps;

      function new();
         cfg_start  = 0;
         cfg_end    = 0;
         cfg_inc    = 0;
         cfg_hold   = 0;
         cfg_step   = longint'(STEP_RESET);
         ramp_value = 0;
         out_level  = 0;
         hold_count = 0;
         going_up   = 1;
         finished   = 0;
         mismatches = 0;
         ticks      = 0;
         starts     = 0;
         done_ticks = 0;
         clipped    = 0;
         snaps      = 0;
      endfunction

      function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
         case (idx)
            REG_START_LEVEL:    cfg_start = longint'($signed(value));
            REG_END_LEVEL:      cfg_end   = longint'($signed(value));
            REG_RAMP_INCREMENT: cfg_inc   = longint'(value[INC_BITS-1:0]);
            REG_HOLD_RELOAD:    cfg_hold  = longint'(value);
            REG_LEVEL_STEP:     cfg_step  = longint'(value[STEP_BITS-1:0]);
            default: ;
         endcase
      endfunction

      function void take_command(logic func, logic restart);
         longint         s, gap, lv, lim_hi, lim_lo;
         level_beat_type beat;
         if (func == FUNC_START) begin
            going_up = (cfg_end >= cfg_start);
            if (restart) out_level = cfg_start;
            ramp_value = out_level;
            hold_count = cfg_hold;
            finished   = 0;
            starts++;
            return;
         end
         ticks++;
         if (!finished) begin
            if (going_up ? (ramp_value < cfg_end) : (ramp_value > cfg_end)) begin
               ramp_value = going_up ? ramp_value + cfg_inc : ramp_value - cfg_inc;
               if (hold_count > 0) begin
                  hold_count -= longint'(1) << HOLD_FRAC_BITS;
               end else begin
                  // hold expired: reload, then step output past the ramp
                  s = (cfg_step == 0) ? 1 : cfg_step;
                  hold_count = cfg_hold;
                  snaps++;
                  if (going_up && out_level < ramp_value) begin
                     gap = ramp_value - out_level;
                     out_level += ((gap + s - 1) / s) * s;
                  end else if (!going_up && out_level > ramp_value) begin
                     gap = out_level - ramp_value;
                     out_level -= ((gap + s - 1) / s) * s;
                  end
               end
            end else begin
               out_level = cfg_end;
               finished  = 1;
            end
         end
         lim_hi = (longint'(1) << (LEVEL_BITS - 1)) - 1;
         lim_lo = -lim_hi - 1;
         lv = out_level;
         if (lv > lim_hi) lv = lim_hi;
         if (lv < lim_lo) lv = lim_lo;
         if (lv != out_level) clipped++;
         if (finished) done_ticks++;
         beat.level    = lv[LEVEL_BITS-1:0];
         beat.done_res = finished;
         levels_due.push_back(beat);
      endfunction

      task flag_mismatch(string what);
         $display("MISMATCH @%0t: %s", $time, what);
         mismatches++;
      endtask

      task match_level(logic signed [LEVEL_BITS-1:0] level, logic done_res);
         level_beat_type want;
         if (levels_due.size() == 0) begin
            flag_mismatch($sformatf("level beat %0d with no tick outstanding", level));
            return;
         end
         want = levels_due.pop_front();
         if (level !== want.level)
            flag_mismatch($sformatf("level %0d, expected %0d", level, want.level));
         if (done_res !== want.done_res)
            flag_mismatch($sformatf("done_res %b, expected %b", done_res, want.done_res));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, buses, DUT
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [ADDR_BITS-1:0]  paddr;
   logic [CFG_BITS-1:0]   pwdata;
   logic [CFG_BITS-1:0]   prdata;
   logic                  pready;

   qrs_req_if req_bus ();
   qrs_rsp_if rsp_bus ();

   ramp_level_tracker tracker;
   int items_sent;
   int settings;
   int hold_offs;
   bit steady;        // last part of the run: both sides stream
   bit gappy;         // sender idles during this segment
   bit hold_off_req;  // ask the receiver for one long stall

   initial clock = 1'b0;
   always #5 clock = ~clock;

   quantized_ramp_segment i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // -------------------------------------------------------------------------
   // Monitor: inputs only change at the falling edge, so everything read here
   // is the value the DUT sees at this rising edge. Commands are noted before
   // results; a result never belongs to a beat accepted at the same edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.take_command(req_bus.func, req_bus.restart_level);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.match_level(rsp_bus.level, rsp_bus.done_res);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stall bursts, quiet stretches, and one long hold-off on
   // request so the output register fills and req_ready drops.
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int quiet;
      int n;
      rsp_bus.ready = 1'b0;
      quiet = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 0;
            hold_offs++;
            rsp_bus.ready = 1'b0;
            for (n = 1; n < HOLD_OFF_CYCLES; n++) @(negedge clock);
         end else if (steady || quiet > 0) begin
            rsp_bus.ready = 1'b1;
            if (quiet > 0) quiet--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_bus.ready = 1'b0;
            n = $urandom_range(1, 10);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
            if ($urandom_range(0, 15) == 0) quiet = $urandom_range(20, 80);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------

   // One request beat; valid stays up afterwards until the next drive.
   task automatic send_beat(logic func, logic restart);
      @(negedge clock);
      req_bus.valid         = 1'b1;
      req_bus.func          = func;
      req_bus.restart_level = restart;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (items_sent >= STEADY_FROM) steady = 1;
   endtask

   // Occasional idle burst ahead of a beat.
   task automatic req_gap();
      int n;
      if (!steady && gappy && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 10);
         repeat (n) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
         end
      end
   endtask

   // Stop sending, wait for every outstanding level, then let a start or a
   // last quantize loop settle before registers change.
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (tracker.levels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(negedge clock);
   endtask

   // APB write: setup, access, register lands at the edge with pready high.
   task automatic csr_write(logic [REG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      tracker.write_reg(idx, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic write_setting(logic [CFG_BITS-1:0] y0, logic [CFG_BITS-1:0] y1,
                                logic [CFG_BITS-1:0] inc, logic [CFG_BITS-1:0] hold,
                                logic [CFG_BITS-1:0] step, bit all);
      if (all || $urandom_range(0, 2) != 0) csr_write(REG_START_LEVEL, y0);
      if (all || $urandom_range(0, 2) != 0) csr_write(REG_END_LEVEL, y1);
      if (all || $urandom_range(0, 2) != 0) csr_write(REG_RAMP_INCREMENT, inc);
      if (all || $urandom_range(0, 2) != 0) csr_write(REG_HOLD_RELOAD, hold);
      if (all || $urandom_range(0, 2) != 0) csr_write(REG_LEVEL_STEP, step);
      settings++;
   endtask

   function automatic logic [CFG_BITS-1:0] pick_level();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '0;
         3:       return $urandom_range(0, 32'h0400_0000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [CFG_BITS-1:0] clip_to_31(longint v);
      return (v > longint'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : CFG_BITS'(v);
   endfunction

   // One random segment: new (partial) setting, usually a start, then about
   // enough ticks to reach the target plus a few pinned ones. A few stray
   // starts and restart_level bits on ticks are mixed in.
   task automatic run_segment(int seg);
      logic [CFG_BITS-1:0] y0, y1, inc, hold, step;
      longint span;
      int len, n_ticks, k;
      drain_results();
      y0 = pick_level();
      y1 = ($urandom_range(0, 9) == 0) ? y0 : pick_level();
      span = longint'($signed(y1)) - longint'($signed(y0));
      if (span < 0) span = -span;
      len = $urandom_range(1, 40);
      case ($urandom_range(0, 11))
         0:       inc = '0;
         1:       inc = 32'h7FFF_FFFF;
         2:       inc = $urandom();   // bit 31 has no home in the register
         default: inc = clip_to_31(span / len);
      endcase
      case ($urandom_range(0, 9))
         0:       hold = '0;
         1:       hold = 32'hFFFF_FFFF;
         2:       hold = $urandom();
         default: hold = $urandom_range(0, 6 << HOLD_FRAC_BITS);
      endcase
      case ($urandom_range(0, 9))
         0:       step = '0;
         1:       step = 32'h7FFF_FFFF;
         2:       step = 32'd1;
         3:       step = $urandom();
         4:       step = CFG_BITS'(STEP_RESET);
         default: step = clip_to_31(span / $urandom_range(1, 12));
      endcase
      write_setting(y0, y1, inc, hold, step, seg == 0);

      // now and then the receiver sits out a long stretch mid-segment
      if (seg % 23 == 11 && !steady) hold_off_req = 1;
      gappy = ($urandom_range(0, 3) != 0);

      if ($urandom_range(0, 9) != 0) send_beat(FUNC_START, $urandom_range(0, 1));
      n_ticks = len + $urandom_range(2, 8);
      for (k = 0; k < n_ticks && items_sent < ITEM_TARGET; k++) begin
         req_gap();
         if ($urandom_range(0, 24) == 0)
            send_beat(FUNC_START, $urandom_range(0, 1));
         else
            send_beat(FUNC_TICK, $urandom_range(0, 1));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int seg;
      tracker      = new();
      items_sent   = 0;
      settings     = 0;
      hold_offs    = 0;
      steady       = 0;
      gappy        = 0;
      hold_off_req = 0;
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_TICK;
      req_bus.restart_level = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Reset setting: both levels 0, so the first tick pins and sets done;
      // restart_level on a tick must do nothing; a start clears done.
      send_beat(FUNC_TICK, 1'b1);
      send_beat(FUNC_TICK, 1'b0);
      send_beat(FUNC_START, 1'b0);
      send_beat(FUNC_TICK, 1'b0);
      drain_results();

      // Full-scale rise, widest step, no hold: output overshoots and clips high.
      write_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 32'h7FFF_FFFF, 1);
      send_beat(FUNC_START, 1'b1);
      repeat (4) send_beat(FUNC_TICK, 1'b0);
      drain_results();

      // Full-scale fall, zero step (lands on the ramp), 1.5-tick hold so the
      // counter dips below zero; last snap goes below range and clips low.
      write_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h3000_0000, 32'h0000_0180, '0, 1);
      send_beat(FUNC_START, 1'b1);
      send_beat(FUNC_TICK, 1'b0);
      send_beat(FUNC_TICK, 1'b1);
      send_beat(FUNC_TICK, 1'b0);
      send_beat(FUNC_TICK, 1'b1);
      send_beat(FUNC_TICK, 1'b0);
      send_beat(FUNC_TICK, 1'b0);
      drain_results();

      // Zero increment, longest hold: ramp stands above the target, no done.
      csr_write(REG_RAMP_INCREMENT, '0);
      csr_write(REG_HOLD_RELOAD, 32'hFFFF_FFFF);
      csr_write(REG_START_LEVEL, '0);
      settings++;
      send_beat(FUNC_START, 1'b1);
      send_beat(FUNC_TICK, 1'b1);
      send_beat(FUNC_TICK, 1'b0);

      // Random segments
      items_sent = 0;
      seg = 0;
      while (items_sent < ITEM_TARGET) begin
         run_segment(seg);
         seg++;
      end

      drain_results();
      $display("Covered %0d ticks and %0d starts over %0d register settings, %0d long hold-offs.",
               tracker.ticks, tracker.starts, settings, hold_offs);
      $display("Saw %0d quantize updates, %0d ticks at target, %0d clipped levels; %0d mismatches.",
               tracker.snaps, tracker.done_ticks, tracker.clipped, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.levels_due.size() == 0)
         $display("tb_quantized_ramp_segment passed");
      else
         $display("tb_quantized_ramp_segment failed");
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles, %0d levels still outstanding",
               cycles, tracker.levels_due.size());
      $display("tb_quantized_ramp_segment failed");
      $finish;
   end

endmodule
